### rtl/core/assert_macros.svh
// Assertion macros used by the sharpen filter RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GS_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Property whose consequent must hold at the clock after the antecedent.
`define GS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/gs3_pkg.sv
// Package for the 3x3 grayscale sharpen filter: types, codes and helper functions.
// No dependencies; every other .sv file of the block uses it.
`timescale 1ns / 1ps

package gs3_pkg;

	typedef logic [7:0] pix_t;
	// Window element index is column * 3 + row, column 0 being the oldest.
	typedef pix_t [8:0] win_t;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam int unsigned RESET_WIDTH = 640;
	localparam int unsigned RESET_HEIGHT = 480;

	// What an accepted item does, decided from the position counters.
	typedef struct packed {
		logic pix_acc;   // pixel item that shifts the window and writes the stores
		logic has_res;   // item yields one result
		logic interior;  // result pixel is sharpened, not passed through
		logic last;      // result is the final pixel of the frame
		logic drain_a;   // drain result comes from the newest line store
	} item_ctl_t;

	// A size of zero acts as one, a size above the maximum acts as the maximum.
	function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
		int unsigned r;
		r = v;
		if (v == 0) begin
			r = 1;
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	// (32*center - 2*neighbors + 8) / 16, clamped to 0..255. Halved form:
	// t = 16*center - neighbors, result = (t + 4) >> 3.
	function automatic pix_t sharpen(input win_t win);
		logic [10:0] nsum;
		logic signed [13:0] t;
		logic signed [13:0] r;
		logic [10:0] q;
		pix_t res;
		nsum = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				nsum = nsum + 11'(win[i]);
			end
		end
		t = $signed({2'b00, win[4], 4'b0000}) - $signed({3'b000, nsum});
		r = t + 14'sd4;
		q = r[13:3];
		if (t < 0) begin
			res = '0;
		end else if (q > 11'd255) begin
			res = 8'hFF;
		end else begin
			res = q[7:0];
		end
		return res;
	endfunction

endpackage

### rtl/core/gs3_if.sv
// Valid/ready stream interfaces for the input items and result items.
// Depends on gs3_pkg for the pixel type.
`timescale 1ns / 1ps

interface gs3_pix_if;
	logic valid;
	logic ready;
	logic req_type;
	gs3_pkg::pix_t pixel_in;

	modport source(output valid, output req_type, output pixel_in, input ready);
	modport sink(input valid, input req_type, input pixel_in, output ready);
endinterface

interface gs3_res_if;
	logic valid;
	logic ready;
	gs3_pkg::pix_t pixel_out;
	logic frame_last;

	modport source(output valid, output pixel_out, output frame_last, input ready);
	modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

### rtl/core/gs3_line_buf.sv
// Two line stores of the sharpen filter, each one write port and one registered read port.
// Depends on gs3_pkg for the pixel type.
`timescale 1ns / 1ps

module gs3_line_buf #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic clk,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic wa_en,
	input  logic [AW-1:0] wa_addr,
	input  gs3_pkg::pix_t wa_data,
	input  logic wb_en,
	input  logic [AW-1:0] wb_addr,
	input  gs3_pkg::pix_t wb_data,
	output gs3_pkg::pix_t rd_a_q,
	output gs3_pkg::pix_t rd_b_q
);

	gs3_pkg::pix_t mem_a [DEPTH];
	gs3_pkg::pix_t mem_b [DEPTH];

	// Reads return the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (wa_en) begin
			mem_a[wa_addr] <= wa_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_a[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			mem_b[wb_addr] <= wb_data;
		end
		if (rd_en) begin
			rd_b_q <= mem_b[rd_addr];
		end
	end

endmodule

### rtl/core/gs3_window.sv
// 3x3 window registers and the sharpen arithmetic of the filter.
// Depends on gs3_pkg for the window type and the sharpen function.
`timescale 1ns / 1ps

module gs3_window (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  gs3_pkg::pix_t va,
	input  gs3_pkg::pix_t vb,
	input  gs3_pkg::pix_t pix,
	output gs3_pkg::pix_t sharp,
	output gs3_pkg::pix_t center
);

	gs3_pkg::win_t win_q;
	gs3_pkg::win_t win_next;

	// The oldest column drops out; the new column is two stores and the incoming pixel.
	assign win_next = gs3_pkg::win_t'({pix, va, vb, win_q[8:3]});
	assign sharp = gs3_pkg::sharpen(win_next);
	assign center = win_next[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (step) begin
			win_q <= win_next;
		end
	end

endmodule

### rtl/core/gs3_seq.sv
// Frame size registers and input/output position counters of the sharpen filter.
// Depends on gs3_pkg for codes, the control struct and the size clamp.
`timescale 1ns / 1ps

module gs3_seq #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [gs3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gs3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic accept,
	input  logic req_type,
	output gs3_pkg::item_ctl_t dec,
	output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam logic [WW-1:0] RST_W =
		WW'(gs3_pkg::eff_size(gs3_pkg::RESET_WIDTH, MAX_WIDTH));
	localparam logic [RW-1:0] RST_H =
		RW'(gs3_pkg::eff_size(gs3_pkg::RESET_HEIGHT, MAX_HEIGHT));

	logic [WW-1:0] eff_w_q;
	logic [RW-1:0] eff_h_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;

	logic [CW-1:0] w_m1;
	logic [HW-1:0] h_m1;
	logic small_frame;
	logic in_done;
	logic primed;
	logic is_drain;

	assign w_m1 = CW'(eff_w_q - WW'(1));
	assign h_m1 = HW'(eff_h_q - RW'(1));
	assign small_frame = (eff_w_q < WW'(3)) || (eff_h_q < RW'(3));
	assign in_done = (in_row_q == eff_h_q);
	// At least one row plus one pixel of the frame has come in.
	assign primed = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign is_drain = (req_type == gs3_pkg::REQ_DRAIN);

	always_comb begin
		dec.pix_acc = !is_drain && !in_done;
		dec.has_res = is_drain ? in_done : (!in_done && primed);
		dec.last = (out_row_q == h_m1) && (out_col_q == w_m1);
		dec.interior = !small_frame && (out_row_q != '0) && (out_row_q != h_m1) &&
			(out_col_q != '0) && (out_col_q != w_m1);
		dec.drain_a = (out_row_q == h_m1);
		rd_addr = is_drain ? out_col_q : in_col_q;
		wr_addr = in_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= RST_W;
			eff_h_q <= RST_H;
		end else if (cfg_we) begin
			if (cfg_index == gs3_pkg::CFG_FRAME_WIDTH) begin
				eff_w_q <= WW'(gs3_pkg::eff_size(32'(cfg_data), MAX_WIDTH));
			end else begin
				eff_h_q <= RW'(gs3_pkg::eff_size(32'(cfg_data), MAX_HEIGHT));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we || (accept && dec.has_res && dec.last)) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (dec.pix_acc) begin
				if (in_col_q == w_m1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (dec.has_res) begin
				if (out_col_q == w_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

endmodule

### rtl/core/gray_sharpen_3x3.sv
// Top level of the streaming 3x3 sharpen filter for 8-bit grayscale frames.
// Depends on gs3_pkg, gs3_if, gs3_seq, gs3_line_buf, gs3_window and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// The filter takes one item per clock and keeps that rate for as long as results are
// taken. An item is accepted into a stage that holds the registered line store reads;
// when that stage moves on, the window shifts, the sharpened or passed-through pixel is
// formed and it lands in the output register, from which the result is offered. The
// figure of one item per cycle is set by the two line stores, each with one write port
// and one read port: the newest store is written as the item is accepted, the older
// store as that stage retires the same item, with a bypass when a read hits that
// pending write. Results trail the pixels by one row plus one pixel; after the last
// pixel of a frame, drain items push out the remaining results, the final one flagged
// with frame_last. Pixel items beyond the frame and drain items with nothing to push
// yield no result. Frame sizes are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT, and a
// size write restarts the frame, so sizes should only be written while the block is
// idle. The line stores are not cleared after reset, as no result reads an entry that
// the current frame has not written.
module gray_sharpen_3x3 #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [gs3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gs3_pkg::CFG_DATA_W-1:0] cfg_data,
	gs3_pix_if.sink pixels,
	gs3_res_if.source results
);

	localparam int CW = $clog2(MAX_WIDTH);

	gs3_pkg::item_ctl_t dec;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] wr_addr;
	logic accept;

	// Stage 1 registers: decision, pixel, column and bypass value of the accepted item.
	logic valid_s1;
	gs3_pkg::item_ctl_t ctl_s1;
	gs3_pkg::pix_t pix_s1;
	logic [CW-1:0] addr_s1;
	logic fwd_s1;
	gs3_pkg::pix_t fwd_val_s1;

	gs3_pkg::pix_t rd_a_q;
	gs3_pkg::pix_t rd_b_q;
	gs3_pkg::pix_t vb;
	gs3_pkg::pix_t sharp;
	gs3_pkg::pix_t center;
	gs3_pkg::pix_t res_pix;
	logic go_s1;
	logic step;
	logic fwd_hit;

	logic out_valid_q;
	gs3_pkg::pix_t out_pix_q;
	logic out_last_q;

	// Stage 1 moves on when it carries no result or the output register has room.
	assign go_s1 = valid_s1 && (!ctl_s1.has_res || !out_valid_q || results.ready);
	assign pixels.ready = !valid_s1 || go_s1;
	assign accept = pixels.valid && pixels.ready;
	assign step = go_s1 && ctl_s1.pix_acc;

	// The older store is written as stage 1 retires; a read of that same column in the
	// same cycle sees the old entry, so the value being written is carried along.
	assign fwd_hit = valid_s1 && ctl_s1.pix_acc && (addr_s1 == rd_addr);
	assign vb = fwd_s1 ? fwd_val_s1 : rd_b_q;

	gs3_seq #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.req_type(pixels.req_type),
		.dec(dec),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr)
	);

	gs3_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_line_buf (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(rd_addr),
		.wa_en(accept && dec.pix_acc),
		.wa_addr(wr_addr),
		.wa_data(pixels.pixel_in),
		.wb_en(step),
		.wb_addr(addr_s1),
		.wb_data(rd_a_q),
		.rd_a_q(rd_a_q),
		.rd_b_q(rd_b_q)
	);

	gs3_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.va(rd_a_q),
		.vb(vb),
		.pix(pix_s1),
		.sharp(sharp),
		.center(center)
	);

	// Pixel items give the window center, sharpened when it is an interior pixel;
	// drain items read the edge pixel straight from the line stores.
	always_comb begin
		if (ctl_s1.pix_acc) begin
			res_pix = ctl_s1.interior ? sharp : center;
		end else begin
			res_pix = ctl_s1.drain_a ? rd_a_q : vb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			ctl_s1 <= dec;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixels.pixel_in;
			addr_s1 <= wr_addr;
			fwd_s1 <= fwd_hit;
			fwd_val_s1 <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && ctl_s1.has_res) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && ctl_s1.has_res) begin
			out_pix_q <= res_pix;
			out_last_q <= ctl_s1.last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.pixel_out = out_pix_q;
	assign results.frame_last = out_last_q;

	// A result waiting in stage 1 behind a full, stalled output blocks new items.
	`GS_ASSERT(a_stall_blocks_input, (valid_s1 && ctl_s1.has_res && out_valid_q && !results.ready) |-> !pixels.ready, "input accepted while stage 1 is stalled")

	// Only a drain item can close a frame: the last result trails every pixel.
	`GS_ASSERT(a_last_from_drain, (accept && dec.has_res && dec.last) |-> (pixels.req_type == gs3_pkg::REQ_DRAIN), "frame closed by a pixel item")

	// A result shows up only after stage 1 retired an item that carries one.
	`GS_ASSERT_NEXT(a_result_source, !out_valid_q && !(go_s1 && ctl_s1.has_res), !out_valid_q, "result appeared without a source item")

endmodule

### verif/sharpen_tb_pkg.sv
// Scoreboard for the 3x3 grayscale sharpen filter testbench: a per-pixel predictor
// and the queue of results it is still waiting for. Depends on gs3_pkg.
`timescale 1ns / 1ps

package sharpen_tb_pkg;

	import gs3_pkg::*;

	localparam int unsigned MAX_COLS = 4096;
	localparam int unsigned MAX_ROWS = 4096;

	typedef struct packed {
		pix_t pix;
		logic last;
	} frame_result_t;

	class sharpen_board;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		pix_t line_new [MAX_COLS];
		pix_t line_old [MAX_COLS];
		// Window element index is column * 3 + row, column 0 being the oldest.
		pix_t win [9];
		int unsigned in_col;
		int unsigned in_row;
		int unsigned out_col;
		int unsigned out_row;
		frame_result_t due_pixels [$];
		int errors;

		function new();
			width_reg = CFG_DATA_W'(RESET_WIDTH);
			height_reg = CFG_DATA_W'(RESET_HEIGHT);
			for (int i = 0; i < MAX_COLS; i++) begin
				line_new[i] = '0;
				line_old[i] = '0;
			end
			for (int i = 0; i < 9; i++) begin
				win[i] = '0;
			end
			restart();
			errors = 0;
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		// Zero acts as one, anything above the maximum acts as the maximum.
		function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned top);
			if (v == 0) return 1;
			if (v > top) return top;
			return 32'(v);
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			if (idx == CFG_FRAME_WIDTH) begin
				width_reg = v;
			end else begin
				height_reg = v;
			end
			restart();
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction

		// Moves the output position on by one pixel and reports the frame end.
		function logic step_out(int unsigned w, int unsigned h);
			if (out_row == h - 1 && out_col == w - 1) begin
				restart();
				return 1'b1;
			end
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			return 1'b0;
		endfunction

		function void predict_item(logic req, pix_t pix);
			int unsigned w;
			int unsigned h;
			int unsigned x;
			int unsigned pos;
			int acc;
			bit interior;
			frame_result_t r;
			w = clamp_size(width_reg, MAX_COLS);
			h = clamp_size(height_reg, MAX_ROWS);
			if (req == REQ_DRAIN) begin
				if (in_row < h || out_row >= h || out_col >= w) return;
				r.pix = (out_row == h - 1) ? line_new[out_col] : line_old[out_col];
				r.last = step_out(w, h);
				due_pixels.push_back(r);
				return;
			end
			if (in_row >= h || in_col >= w) return;
			x = in_col;
			for (int i = 0; i < 6; i++) begin
				win[i] = win[i + 3];
			end
			win[6] = line_old[x];
			win[7] = line_new[x];
			win[8] = pix;
			line_old[x] = line_new[x];
			line_new[x] = pix;
			pos = in_row * w + x;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (pos < w + 1) return;
			interior = (w >= 3) && (h >= 3) && (out_row >= 1) && (out_row + 2 <= h) &&
				(out_col >= 1) && (out_col + 2 <= w);
			if (interior) begin
				acc = 32 * int'(win[4]);
				for (int i = 0; i < 9; i++) begin
					if (i != 4) acc = acc - 2 * int'(win[i]);
				end
				if (acc < 0) begin
					r.pix = '0;
				end else begin
					acc = (acc + 8) / 16;
					r.pix = (acc > 255) ? 8'hFF : pix_t'(acc);
				end
			end else begin
				r.pix = win[4];
			end
			r.last = step_out(w, h);
			due_pixels.push_back(r);
		endfunction

		function void match_result(pix_t pix, logic last);
			frame_result_t exp_r;
			if (due_pixels.size() == 0) begin
				errors++;
				$display("%0t: result with none due: expected nothing, got pixel_out %0d frame_last %0b",
					$time, pix, last);
				return;
			end
			exp_r = due_pixels.pop_front();
			if (pix !== exp_r.pix) begin
				errors++;
				$display("%0t: pixel_out expected %0d, got %0d", $time, exp_r.pix, pix);
			end
			if (last !== exp_r.last) begin
				errors++;
				$display("%0t: frame_last expected %0b, got %0b", $time, exp_r.last, last);
			end
		endfunction
	endclass

endpackage

### verif/testbench.sv
// Top level of the gray_sharpen_3x3 testbench: clock, reset, stimulus, result
// sink and watchdog. Depends on gs3_pkg, gs3_if, sharpen_tb_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

	import gs3_pkg::*;
	import sharpen_tb_pkg::*;

	// Cycles with no handshake on either channel before the run is declared hung.
	localparam int QUIET_LIMIT = 1000;
	// Extra cycles allowed after the last due result, covering the two-stage pipeline.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS = 500;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gs3_pix_if pix_ch();
	gs3_res_if res_ch();

	gray_sharpen_3x3 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels(pix_ch),
		.results(res_ch)
	);

	sharpen_board sb;
	// Effective frame size that the stimulus is currently building frames for.
	int unsigned cur_w;
	int unsigned cur_h;
	// While set, neither the sender nor the receiver inserts random idle cycles.
	bit no_gaps;
	int unsigned useful_items;

	// A 4x3 frame whose two interior pixels hit both clamps: the bright center at
	// row 1, column 1 saturates high, the dark one next to it goes negative.
	pix_t contrast_rows [12] = '{
		8'h00, 8'h00, 8'hFF, 8'hFF,
		8'h00, 8'hFF, 8'h00, 8'hFF,
		8'h00, 8'h00, 8'hFF, 8'hFF
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Picks a pixel value, weighted toward the extremes that drive the clamps.
	function automatic pix_t rand_pixel();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return pix_t'($urandom);
	endfunction

	// Offers one item from a falling edge, with random idle cycles in front of it,
	// and returns at the falling edge after the item was taken. The predictor sees
	// the item at the very rising edge where valid and ready were both high.
	task automatic send_item(input logic req, input pix_t pix);
		while (!no_gaps && $urandom_range(99) < 21) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.req_type <= req;
		pix_ch.pixel_in <= pix;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		sb.predict_item(req, pix);
		@(negedge clk);
	endtask

	// Holds the sender back until every due result has been taken. Valid is only
	// lowered when there is something to wait for, so it never gets two updates
	// in the same step.
	task automatic hold_for_results();
		if (sb.pending() != 0) begin
			pix_ch.valid <= 1'b0;
			while (sb.pending() != 0) @(negedge clk);
		end
	endtask

	// Drains the block completely: no results due, then the SETTLE_CYCLES wait for the pipeline.
	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both size registers on back-to-back cycles once the block is idle.
	// Either write restarts the frame in the block and in the predictor.
	task automatic set_size(input logic [CFG_DATA_W-1:0] w_val,
			input logic [CFG_DATA_W-1:0] h_val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w_val;
		sb.write_reg(CFG_FRAME_WIDTH, w_val);
		@(negedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h_val;
		sb.write_reg(CFG_FRAME_HEIGHT, h_val);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_w = sb.clamp_size(w_val, MAX_COLS);
		cur_h = sb.clamp_size(h_val, MAX_ROWS);
	endtask

	// Sends one frame of random pixels at the current size. Early drain ticks are
	// sprinkled in as noise. A broken frame stops at a random pixel and is left
	// for the next size write to abandon; a whole frame may be followed by a few
	// surplus pixels, which the block must ignore, and then enough drain ticks
	// to push out the trailing row plus one pixel, with up to two to spare.
	task automatic random_frame(input bit broken, input bit force_hold);
		int unsigned total;
		int unsigned stop;
		total = cur_w * cur_h;
		stop = broken ? $urandom_range(total - 1) : total;
		for (int unsigned i = 0; i < stop; i++) begin
			if ($urandom_range(99) < 4) send_item(REQ_DRAIN, pix_t'($urandom));
			if ($urandom_range(99) == 0) hold_for_results();
			send_item(REQ_PIXEL, rand_pixel());
			useful_items++;
		end
		if (!broken) begin
			if (force_hold || $urandom_range(3) == 0) hold_for_results();
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3)) send_item(REQ_PIXEL, rand_pixel());
			end
			repeat (cur_w + 1 + $urandom_range(2)) send_item(REQ_DRAIN, pix_t'($urandom));
			useful_items += cur_w + 1;
		end
	endtask

	// Result side: ready changes at the falling edge, results are taken at the
	// rising edge and checked against the oldest prediction.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= no_gaps || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			sb.match_result(res_ch.pixel_out, res_ch.frame_last);
		end
	end

	// Watchdog: any handshake on either channel resets the count of quiet cycles.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("gray_sharpen_3x3 test failed");
		$finish;
	end

	initial begin
		int unsigned frame_no;
		bit broken;
		bit need_restart;
		sb = new();
		no_gaps = 1'b0;
		useful_items = 0;
		cur_w = RESET_WIDTH;
		cur_h = RESET_HEIGHT;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.req_type = REQ_PIXEL;
		pix_ch.pixel_in = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The contrast frame, with a drain tick while pixels are
		// still arriving, a surplus pixel once the frame is complete, and one
		// drain tick more than there are results left to push out.
		set_size(13'd4, 13'd3);
		for (int i = 0; i < 12; i++) begin
			if (i == 2) send_item(REQ_DRAIN, 8'hFF);
			send_item(REQ_PIXEL, contrast_rows[i]);
		end
		send_item(REQ_PIXEL, 8'hA5);
		repeat (6) send_item(REQ_DRAIN, 8'h00);
		// A frame cut short by a size write, then sizes of zero, which act as one.
		send_item(REQ_PIXEL, 8'h5A);
		send_item(REQ_PIXEL, 8'hC3);
		set_size(13'd0, 13'd0);
		send_item(REQ_PIXEL, 8'h80);
		repeat (2) send_item(REQ_DRAIN, 8'h7F);

		// Random part: small frames of random size, mostly whole, a few broken off
		// midway. Some frames reuse the previous size without a write, which checks
		// that the block starts over by itself after the final pixel. A run of
		// frames goes through with no random idle cycles on either side.
		frame_no = 0;
		need_restart = 1'b1;
		while (useful_items < RANDOM_ITEMS) begin
			if (need_restart || $urandom_range(9) < 7) begin
				set_size(CFG_DATA_W'($urandom_range(9)), CFG_DATA_W'($urandom_range(6)));
			end
			no_gaps = (frame_no >= 6 && frame_no < 10);
			broken = (frame_no != 0) && ($urandom_range(9) == 0);
			random_frame(broken, frame_no == 0);
			need_restart = broken;
			frame_no++;
		end
		no_gaps = 1'b0;

		// All-ones sizes act as the maximum. Such a frame is far too long to run
		// through, so only a few pixels and a drain tick go in, none of which may
		// yield a result.
		set_size(13'h1FFF, 13'h1FFF);
		repeat (16) send_item(REQ_PIXEL, rand_pixel());
		send_item(REQ_DRAIN, 8'h00);

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("gray_sharpen_3x3 test passed");
		end else begin
			$display("gray_sharpen_3x3 test failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gs3_pkg.sv
rtl/core/gs3_if.sv
rtl/core/gs3_line_buf.sv
rtl/core/gs3_window.sv
rtl/core/gs3_seq.sv
rtl/core/gray_sharpen_3x3.sv
verif/sharpen_tb_pkg.sv
verif/testbench.sv
